// ----- hdl/zia_pkg.sv -----
// ----------------------------------------------------------------------------
// zia_pkg
// Shared constants, register codes and types of the zone intrusion alert.
// ----------------------------------------------------------------------------
package zia_pkg;

    // Geometry and sizes
    localparam int COORD_BITS     = 12;
    localparam int NUM_VERTICES   = 4;
    localparam int NUM_CAMERAS    = 2;
    localparam int HIT_COUNT_BITS = 8;

    // Half-pixel point and vertex width, signed difference width, product width
    localparam int POINT_W = COORD_BITS + 1;
    localparam int DIFF_W  = POINT_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Configuration word widths
    localparam int VERT_REG_W  = 4 * COORD_BITS;
    localparam int CFG_DATA_W  = VERT_REG_W;
    localparam int COOLDOWN_W  = 31;
    localparam int TIME_W      = 32;
    localparam int HIT_OUT_W   = 8;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CAM0_V01  = 3'd0,
        CFG_CAM0_V23  = 3'd1,
        CFG_CAM1_V01  = 3'd2,
        CFG_CAM1_V23  = 3'd3,
        CFG_ZONE_MASK = 3'd4,
        CFG_COOLDOWN  = 3'd5
    } cfg_index_t;

    typedef logic [POINT_W-1:0] point_t;

    // Result of one polygon edge
    typedef struct packed {
        logic on_edge;
        logic flip;
    } edge_res_t;

    // Frame-end status towards the result register
    typedef struct packed {
        logic                 intrusion;
        logic                 alert;
        logic [HIT_OUT_W-1:0] hit_count;
    } frame_res_t;

endpackage

// ----- hdl/zone_intrusion_alert.sv -----
// ----------------------------------------------------------------------------
// zone_intrusion_alert
// Tests detection box centres against a per-camera zone and raises alerts.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the zone test
//   and frame-state update are one combinational pass between the two registers.
// Reset: clears configuration, hit counter, intrusion history, alert times
//   and both valid flags; the block accepts items right after reset.
// ----------------------------------------------------------------------------
module zone_intrusion_alert (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [zia_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           camera,
    input  logic [11:0]                    box_left,
    input  logic [11:0]                    box_top,
    input  logic [11:0]                    box_right,
    input  logic [11:0]                    box_bottom,
    input  logic                           box_present,
    input  logic                           frame_last,
    input  logic [31:0]                    now_ms,
    // Result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_camera,
    output logic                           inside_res,
    output logic                           frame_done,
    output logic                           intrusion,
    output logic [7:0]                     hit_count,
    output logic                           alert,
    output logic                           zone_active
);

    localparam int C = zia_pkg::COORD_BITS;

    // Configuration registers
    logic [zia_pkg::VERT_REG_W-1:0]  vert_lo_reg [zia_pkg::NUM_CAMERAS];
    logic [zia_pkg::VERT_REG_W-1:0]  vert_hi_reg [zia_pkg::NUM_CAMERAS];
    logic [zia_pkg::NUM_CAMERAS-1:0] zone_mask_reg;
    logic [zia_pkg::COOLDOWN_W-1:0]  cooldown_reg;

    // Input register
    logic        s1_valid_reg;
    logic        s1_camera_reg;
    logic [11:0] s1_left_reg;
    logic [11:0] s1_top_reg;
    logic [11:0] s1_right_reg;
    logic [11:0] s1_bottom_reg;
    logic        s1_present_reg;
    logic        s1_last_reg;
    logic [31:0] s1_now_reg;

    // Result register
    logic        out_valid_reg;
    logic        out_camera_reg;
    logic        out_inside_reg;
    logic        out_done_reg;
    logic        out_intr_reg;
    logic [7:0]  out_hits_reg;
    logic        out_alert_reg;
    logic        out_active_reg;

    logic                   s1_advance;
    logic                   active;
    logic                   in_zone;
    logic                   box_hit;
    zia_pkg::point_t        px;
    zia_pkg::point_t        py;
    zia_pkg::point_t        vx [zia_pkg::NUM_VERTICES];
    zia_pkg::point_t        vy [zia_pkg::NUM_VERTICES];
    zia_pkg::frame_res_t    frame_res;
    logic [zia_pkg::VERT_REG_W-1:0] vsel_lo;
    logic [zia_pkg::VERT_REG_W-1:0] vsel_hi;

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || !out_valid_reg || out_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int c = 0; c < zia_pkg::NUM_CAMERAS; c++) begin
                vert_lo_reg[c] <= '0;
                vert_hi_reg[c] <= '0;
            end
            zone_mask_reg <= '0;
            cooldown_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (zia_pkg::cfg_index_t'(cfg_index))
                zia_pkg::CFG_CAM0_V01:  vert_lo_reg[0] <= cfg_data[zia_pkg::VERT_REG_W-1:0];
                zia_pkg::CFG_CAM0_V23:  vert_hi_reg[0] <= cfg_data[zia_pkg::VERT_REG_W-1:0];
                zia_pkg::CFG_CAM1_V01:  vert_lo_reg[1] <= cfg_data[zia_pkg::VERT_REG_W-1:0];
                zia_pkg::CFG_CAM1_V23:  vert_hi_reg[1] <= cfg_data[zia_pkg::VERT_REG_W-1:0];
                zia_pkg::CFG_ZONE_MASK: zone_mask_reg  <= cfg_data[zia_pkg::NUM_CAMERAS-1:0];
                zia_pkg::CFG_COOLDOWN:  cooldown_reg   <= cfg_data[zia_pkg::COOLDOWN_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture an item into the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            s1_camera_reg  <= camera;
            s1_left_reg    <= box_left;
            s1_top_reg     <= box_top;
            s1_right_reg   <= box_right;
            s1_bottom_reg  <= box_bottom;
            s1_present_reg <= box_present;
            s1_last_reg    <= frame_last;
            s1_now_reg     <= now_ms;
        end
    end

    // Select the camera's vertices, doubled to half-pixel scale
    assign vsel_lo = vert_lo_reg[s1_camera_reg];
    assign vsel_hi = vert_hi_reg[s1_camera_reg];

    always_comb
    begin
        vx[0] = {vsel_lo[C-1:0],       1'b0};
        vy[0] = {vsel_lo[2*C-1:C],     1'b0};
        vx[1] = {vsel_lo[3*C-1:2*C],   1'b0};
        vy[1] = {vsel_lo[4*C-1:3*C],   1'b0};
        vx[2] = {vsel_hi[C-1:0],       1'b0};
        vy[2] = {vsel_hi[2*C-1:C],     1'b0};
        vx[3] = {vsel_hi[3*C-1:2*C],   1'b0};
        vy[3] = {vsel_hi[4*C-1:3*C],   1'b0};
    end

    // Box centre in half pixels
    assign px = zia_pkg::POINT_W'({1'b0, s1_left_reg} + {1'b0, s1_right_reg});
    assign py = zia_pkg::POINT_W'({1'b0, s1_top_reg} + {1'b0, s1_bottom_reg});

    zia_zone_test u_zone (
        .vx      (vx),
        .vy      (vy),
        .px      (px),
        .py      (py),
        .in_poly (in_zone)
    );

    assign active  = (32'(s1_camera_reg) < zia_pkg::NUM_CAMERAS)
                  && zone_mask_reg[s1_camera_reg];
    assign box_hit = active && s1_present_reg && in_zone;

    zia_frame_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (s1_advance),
        .camera      (s1_camera_reg),
        .box_hit     (box_hit),
        .frame_last  (s1_last_reg),
        .zone_active (active),
        .now_ms      (s1_now_reg),
        .cooldown    (cooldown_reg),
        .res         (frame_res)
    );

    // Load the result register; drop valid once the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance) begin
            out_camera_reg <= s1_camera_reg;
            out_inside_reg <= box_hit;
            out_done_reg   <= s1_last_reg;
            out_intr_reg   <= frame_res.intrusion;
            out_hits_reg   <= frame_res.hit_count;
            out_alert_reg  <= frame_res.alert;
            out_active_reg <= active;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_camera  = out_camera_reg;
    assign inside_res  = out_inside_reg;
    assign frame_done  = out_done_reg;
    assign intrusion   = out_intr_reg;
    assign hit_count   = out_hits_reg;
    assign alert       = out_alert_reg;
    assign zone_active = out_active_reg;

    // Checks
    a_alert_needs_intrusion: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_alert_reg |-> out_intr_reg && out_done_reg && out_active_reg)
        else $error("alert without intrusion at frame end");

    a_intrusion_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_intr_reg |-> out_done_reg && out_active_reg)
        else $error("intrusion reported outside frame end");

    a_inside_needs_zone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_inside_reg |-> out_active_reg)
        else $error("inside reported without an active zone");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with result register empty");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_now_reg))
        else $error("stalled item lost from the input register");

endmodule

// ----- hdl/zia_edge_test.sv -----
// ----------------------------------------------------------------------------
// zia_edge_test
// Tests one zone edge against a point: on-edge check and even-odd crossing.
// ----------------------------------------------------------------------------
module zia_edge_test (
    input  zia_pkg::point_t    ax,
    input  zia_pkg::point_t    ay,
    input  zia_pkg::point_t    bx,
    input  zia_pkg::point_t    by,
    input  zia_pkg::point_t    px,
    input  zia_pkg::point_t    py,
    output zia_pkg::edge_res_t res
);

    logic signed [zia_pkg::DIFF_W-1:0] dx_edge;
    logic signed [zia_pkg::DIFF_W-1:0] dy_edge;
    logic signed [zia_pkg::DIFF_W-1:0] dx_pt;
    logic signed [zia_pkg::DIFF_W-1:0] dy_pt;
    logic signed [zia_pkg::PROD_W-1:0] lhs;
    logic signed [zia_pkg::PROD_W-1:0] rhs;
    logic                              in_box;
    logic                              crosses;
    logic                              dy_pos;

    // Form signed differences relative to the edge start
    assign dx_edge = $signed({1'b0, bx}) - $signed({1'b0, ax});
    assign dy_edge = $signed({1'b0, by}) - $signed({1'b0, ay});
    assign dx_pt   = $signed({1'b0, px}) - $signed({1'b0, ax});
    assign dy_pt   = $signed({1'b0, py}) - $signed({1'b0, ay});

    // Compare the two cross-product terms; equal means collinear
    assign lhs = zia_pkg::PROD_W'(dx_pt) * zia_pkg::PROD_W'(dy_edge);
    assign rhs = zia_pkg::PROD_W'(dy_pt) * zia_pkg::PROD_W'(dx_edge);

    // Check the point lies within the edge's bounding box
    assign in_box = (px >= ((ax < bx) ? ax : bx)) && (px <= ((ax < bx) ? bx : ax))
                 && (py >= ((ay < by) ? ay : by)) && (py <= ((ay < by) ? by : ay));

    // Count a crossing when the edge straddles the point's row on its right
    assign crosses = (ay > py) != (by > py);
    assign dy_pos  = !dy_edge[zia_pkg::DIFF_W-1] && (dy_edge != '0);

    assign res.on_edge = (lhs == rhs) && in_box;
    assign res.flip    = crosses && (dy_pos ? (lhs < rhs) : (lhs > rhs));

endmodule

// ----- hdl/zia_zone_test.sv -----
// ----------------------------------------------------------------------------
// zia_zone_test
// Point in four-vertex polygon: edges tested in parallel, edge points inside.
// ----------------------------------------------------------------------------
module zia_zone_test (
    input  zia_pkg::point_t vx [zia_pkg::NUM_VERTICES],
    input  zia_pkg::point_t vy [zia_pkg::NUM_VERTICES],
    input  zia_pkg::point_t px,
    input  zia_pkg::point_t py,
    output logic            in_poly
);

    zia_pkg::edge_res_t edge_res [zia_pkg::NUM_VERTICES];
    logic [zia_pkg::NUM_VERTICES-1:0] on_edge_vec;
    logic [zia_pkg::NUM_VERTICES-1:0] flip_vec;

    // One tester per edge, closing the polygon from the last vertex to the first
    for (genvar i = 0; i < zia_pkg::NUM_VERTICES; i++) begin : g_edge
        localparam int J = (i + 1) % zia_pkg::NUM_VERTICES;
        zia_edge_test u_edge (
            .ax  (vx[i]),
            .ay  (vy[i]),
            .bx  (vx[J]),
            .by  (vy[J]),
            .px  (px),
            .py  (py),
            .res (edge_res[i])
        );
        assign on_edge_vec[i] = edge_res[i].on_edge;
        assign flip_vec[i]    = edge_res[i].flip;
    end

    // Inside when on any edge or on an odd crossing count
    assign in_poly = (|on_edge_vec) || (^flip_vec);

endmodule

// ----- hdl/zia_frame_state.sv -----
// ----------------------------------------------------------------------------
// zia_frame_state
// Frame hit counter, per-camera intrusion history and alert cooldown.
// ----------------------------------------------------------------------------
module zia_frame_state (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           camera,
    input  logic                           box_hit,
    input  logic                           frame_last,
    input  logic                           zone_active,
    input  logic [zia_pkg::TIME_W-1:0]     now_ms,
    input  logic [zia_pkg::COOLDOWN_W-1:0] cooldown,
    output zia_pkg::frame_res_t            res
);

    localparam logic [zia_pkg::HIT_COUNT_BITS-1:0] HIT_MAX = '1;

    logic [zia_pkg::HIT_COUNT_BITS-1:0] frame_hits_reg;
    logic [zia_pkg::HIT_COUNT_BITS-1:0] frame_hits_next;
    logic [zia_pkg::HIT_COUNT_BITS-1:0] hits_now;
    logic [zia_pkg::HIT_COUNT_BITS+zia_pkg::HIT_OUT_W-1:0] hits_ext;
    logic [zia_pkg::NUM_CAMERAS-1:0]    prev_intr_reg;
    logic [zia_pkg::NUM_CAMERAS-1:0]    prev_intr_next;
    logic [zia_pkg::TIME_W-1:0]         last_alert_reg [zia_pkg::NUM_CAMERAS];
    logic [zia_pkg::TIME_W-1:0]         elapsed;
    logic                               cam_ok;
    logic                               intrusion;
    logic                               alert;

    // Saturating hit count including this item
    assign hits_now = (box_hit && (frame_hits_reg != HIT_MAX))
                    ? frame_hits_reg + 1'b1 : frame_hits_reg;
    assign hits_ext = {{zia_pkg::HIT_OUT_W{1'b0}}, hits_now};

    assign cam_ok  = 32'(camera) < zia_pkg::NUM_CAMERAS;
    assign elapsed = now_ms - last_alert_reg[camera];

    // Decide intrusion and alert at frame end
    assign intrusion = frame_last && cam_ok && zone_active && (hits_now != '0);
    assign alert     = intrusion && !prev_intr_reg[camera]
                    && (elapsed >= {1'b0, cooldown});

    always_comb
    begin
        frame_hits_next = frame_last ? '0 : hits_now;
        prev_intr_next  = prev_intr_reg;
        if (frame_last && cam_ok) begin
            prev_intr_next[camera] = intrusion;
        end
    end

    // Hold state; advance when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_hits_reg <= '0;
            prev_intr_reg  <= '0;
            for (int c = 0; c < zia_pkg::NUM_CAMERAS; c++) begin
                last_alert_reg[c] <= '0;
            end
        end else if (advance) begin
            frame_hits_reg <= frame_hits_next;
            prev_intr_reg  <= prev_intr_next;
            if (alert) begin
                last_alert_reg[camera] <= now_ms;
            end
        end
    end

    assign res.intrusion = intrusion;
    assign res.alert     = alert;
    assign res.hit_count = hits_ext[zia_pkg::HIT_OUT_W-1:0];

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zone intrusion alert. Detection boxes are
// streamed through the item channel while a local model of the zone test,
// hit counter and alert edge logic predicts every result, which is compared
// field by field as it leaves the block. Directed cases cover edges,
// vertices, half-pixel centres, empty markers, cooldown and saturation.
// Random phases then reload the zones and alert settings between bursts of
// frames with random idling on both sides, after a test with one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = zia_pkg::COORD_BITS;
    localparam int HIT_COUNT_BITS = zia_pkg::HIT_COUNT_BITS;
    localparam int NUM_VERTICES   = zia_pkg::NUM_VERTICES;
    localparam int NUM_CAMERAS    = zia_pkg::NUM_CAMERAS;
    localparam int TIME_W         = zia_pkg::TIME_W;
    localparam int HIT_OUT_W      = zia_pkg::HIT_OUT_W;
    localparam int CFG_DATA_W     = zia_pkg::CFG_DATA_W;
    localparam int VERT_REG_W     = zia_pkg::VERT_REG_W;
    localparam int COOLDOWN_W     = zia_pkg::COOLDOWN_W;

    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int PT_MAX       = 2 * COORD_MAX;
    localparam int HIT_MAX      = (1 << HIT_COUNT_BITS) - 1;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    // One detection box item as driven onto the input ports
    typedef struct packed {
        logic                  cam;
        logic [COORD_BITS-1:0] left_px;
        logic [COORD_BITS-1:0] top_px;
        logic [COORD_BITS-1:0] right_px;
        logic [COORD_BITS-1:0] bottom_px;
        logic                  present;
        logic                  last_item;
        logic [TIME_W-1:0]     now_ms;
    } box_item_t;

    // One result item as expected on the output ports
    typedef struct packed {
        logic                 cam;
        logic                 in_zone;
        logic                 done;
        logic                 intr;
        logic [HIT_OUT_W-1:0] hits;
        logic                 raised;
        logic                 active;
    } zone_result_t;

    // Block ports
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [2:0]            cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  camera      = 1'b0;
    logic [11:0]           box_left    = '0;
    logic [11:0]           box_top     = '0;
    logic [11:0]           box_right   = '0;
    logic [11:0]           box_bottom  = '0;
    logic                  box_present = 1'b0;
    logic                  frame_last  = 1'b0;
    logic [31:0]           now_ms      = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic                  out_camera;
    logic                  inside_res;
    logic                  frame_done;
    logic                  intrusion;
    logic [7:0]            hit_count;
    logic                  alert;
    logic                  zone_active;

    // Zone model: configuration copy and frame state
    logic [VERT_REG_W-1:0]     zone_words [NUM_CAMERAS][2];
    logic [NUM_CAMERAS-1:0]    zone_mask       = '0;
    logic [COOLDOWN_W-1:0]     alert_cooldown  = '0;
    logic [HIT_COUNT_BITS-1:0] frame_hits      = '0;
    logic                      prev_intrusion [NUM_CAMERAS];
    logic [TIME_W-1:0]         last_alert_ms  [NUM_CAMERAS];

    zone_result_t      pending_results[$];
    logic [TIME_W-1:0] cam_clock [NUM_CAMERAS];

    int          fail_count  = 0;
    int          cycle_count = 0;
    bit          steady_src  = 1'b0;
    bit          steady_sink = 1'b0;
    int unsigned hold_reqs   = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;

    zone_intrusion_alert dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .camera      (camera),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_right   (box_right),
        .box_bottom  (box_bottom),
        .box_present (box_present),
        .frame_last  (frame_last),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_camera  (out_camera),
        .inside_res  (inside_res),
        .frame_done  (frame_done),
        .intrusion   (intrusion),
        .hit_count   (hit_count),
        .alert       (alert),
        .zone_active (zone_active)
    );

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Zone model
    // ------------------------------------------------------------------------

    // Fetch one vertex coordinate, doubled to half-pixel units
    function automatic longint vert_coord(input bit cam, input int v, input bit is_y);
        logic [VERT_REG_W-1:0] word;
        int                    sh;
        word = zone_words[cam][(v >> 1) & 1];
        sh   = ((v & 1) * 2 + int'(is_y)) * COORD_BITS;
        return 2 * longint'(word[sh +: COORD_BITS]);
    endfunction

    // Even-odd crossing test; points on an edge or a vertex count as inside
    function automatic bit zone_hit(input bit cam, input longint px, input longint py);
        longint ax, ay, bx, by, cr, dy, lhs, rhs, lox, hix, loy, hiy;
        bit     odd;
        int     j;
        odd = 1'b0;
        for (int i = 0; i < NUM_VERTICES; i++)
        begin
            j  = (i + 1) % NUM_VERTICES;
            ax = vert_coord(cam, i, 1'b0);
            ay = vert_coord(cam, i, 1'b1);
            bx = vert_coord(cam, j, 1'b0);
            by = vert_coord(cam, j, 1'b1);
            cr = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
            lox = (ax < bx) ? ax : bx;
            hix = (ax < bx) ? bx : ax;
            loy = (ay < by) ? ay : by;
            hiy = (ay < by) ? by : ay;
            if (cr == 0 && px >= lox && px <= hix && py >= loy && py <= hiy)
                return 1'b1;
            if ((ay > py) != (by > py))
            begin
                dy  = by - ay;
                lhs = (px - ax) * dy;
                rhs = (py - ay) * (bx - ax);
                if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                    odd = !odd;
            end
        end
        return odd;
    endfunction

    // Advance the model by one accepted item and return its result
    function automatic zone_result_t predict_zone_result(input box_item_t it);
        zone_result_t      r;
        logic              was;
        logic [TIME_W-1:0] since;
        longint            px, py;
        r        = '0;
        r.cam    = it.cam;
        r.done   = it.last_item;
        r.active = zone_mask[it.cam];
        px = longint'(it.left_px) + longint'(it.right_px);
        py = longint'(it.top_px) + longint'(it.bottom_px);
        if (r.active && it.present)
            r.in_zone = zone_hit(it.cam, px, py);
        if (r.in_zone && frame_hits < HIT_MAX)
            frame_hits = frame_hits + 1'b1;
        r.hits = HIT_OUT_W'(frame_hits);
        if (it.last_item)
        begin
            if (!r.active)
                prev_intrusion[it.cam] = 1'b0;
            else
            begin
                was    = prev_intrusion[it.cam];
                r.intr = (frame_hits != 0);
                prev_intrusion[it.cam] = r.intr;
                since  = it.now_ms - last_alert_ms[it.cam];
                if (r.intr && !was && since >= {1'b0, alert_cooldown})
                begin
                    last_alert_ms[it.cam] = it.now_ms;
                    r.raised = 1'b1;
                end
            end
            frame_hits = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        zone_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_camera", want.cam, out_camera);
                check_field("inside_res", want.in_zone, inside_res);
                check_field("frame_done", want.done, frame_done);
                check_field("intrusion", want.intr, intrusion);
                check_field("hit_count", want.hits, hit_count);
                check_field("alert", want.raised, alert);
                check_field("zone_active", want.active, zone_active);
            end
        end
    end

    // Output ready: random stalls, steady stretches and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (steady_sink)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 30);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one item, hold it until accepted, then record its prediction
    task automatic send_item(input box_item_t it);
        if (!steady_src && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        camera      <= it.cam;
        box_left    <= it.left_px;
        box_top     <= it.top_px;
        box_right   <= it.right_px;
        box_bottom  <= it.bottom_px;
        box_present <= it.present;
        frame_last  <= it.last_item;
        now_ms      <= it.now_ms;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results = {pending_results, predict_zone_result(it)};
    endtask

    // Write one register; valid stays high until end_config
    task automatic write_reg(input zia_pkg::cfg_index_t idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            zia_pkg::CFG_CAM0_V01:  zone_words[0][0] = data;
            zia_pkg::CFG_CAM0_V23:  zone_words[0][1] = data;
            zia_pkg::CFG_CAM1_V01:  zone_words[1][0] = data;
            zia_pkg::CFG_CAM1_V23:  zone_words[1][1] = data;
            zia_pkg::CFG_ZONE_MASK: zone_mask = data[NUM_CAMERAS-1:0];
            zia_pkg::CFG_COOLDOWN:  alert_cooldown = data[COOLDOWN_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
    endtask

    // Stop offering items and wait until every result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Load the four vertices of one camera's zone
    task automatic set_zone(input bit cam, input int unsigned xs[4], input int unsigned ys[4]);
        write_reg(cam ? zia_pkg::CFG_CAM1_V01 : zia_pkg::CFG_CAM0_V01,
                  {COORD_BITS'(ys[1]), COORD_BITS'(xs[1]),
                   COORD_BITS'(ys[0]), COORD_BITS'(xs[0])});
        write_reg(cam ? zia_pkg::CFG_CAM1_V23 : zia_pkg::CFG_CAM0_V23,
                  {COORD_BITS'(ys[3]), COORD_BITS'(xs[3]),
                   COORD_BITS'(ys[2]), COORD_BITS'(xs[2])});
    endtask

    // Pick a zone shape: rectangle, free quad, degenerate or frame extremes
    task automatic random_zone(input bit cam);
        int unsigned xs[4], ys[4];
        int unsigned x0, x1, y0, y1, kind;
        kind = $urandom_range(9);
        x0 = $urandom_range(COORD_MAX - 1);
        y0 = $urandom_range(COORD_MAX - 1);
        x1 = $urandom_range(COORD_MAX, x0 + 1);
        y1 = $urandom_range(COORD_MAX, y0 + 1);
        if (kind < 4)
        begin
            xs = '{x0, x1, x1, x0};
            ys = '{y0, y0, y1, y1};
        end
        else if (kind < 8)
        begin
            foreach (xs[i])
            begin
                xs[i] = $urandom_range(COORD_MAX);
                ys[i] = $urandom_range(COORD_MAX);
            end
        end
        else if (kind == 8)
        begin
            // coinciding vertices: a single point or a doubled segment
            if ($urandom_range(1))
            begin
                xs = '{x0, x0, x0, x0};
                ys = '{y0, y0, y0, y0};
            end
            else
            begin
                xs = '{x0, x0, x1, x1};
                ys = '{y0, y0, y1, y1};
            end
        end
        else
        begin
            case ($urandom_range(2))
                0:
                begin
                    xs = '{0, COORD_MAX, COORD_MAX, 0};
                    ys = '{0, 0, COORD_MAX, COORD_MAX};
                end
                1:
                begin
                    xs = '{0, 0, 0, 0};
                    ys = '{0, 0, 0, 0};
                end
                default:
                begin
                    xs = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX};
                    ys = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX};
                end
            endcase
        end
        set_zone(cam, xs, ys);
    endtask

    // Fill the unused upper bits of a short register with noise half the time
    function automatic logic [CFG_DATA_W-1:0] pad_noise(input logic [CFG_DATA_W-1:0] value,
                                                        input int used_bits);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'({$urandom, $urandom});
        if ($urandom_range(1))
            return value;
        return (noise << used_bits) | value;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------

    function automatic box_item_t raw_item(input bit cam, input int l, input int t,
                                           input int r, input int b, input bit present,
                                           input bit last, input logic [TIME_W-1:0] stamp);
        box_item_t it;
        it.cam       = cam;
        it.left_px   = COORD_BITS'(l);
        it.top_px    = COORD_BITS'(t);
        it.right_px  = COORD_BITS'(r);
        it.bottom_px = COORD_BITS'(b);
        it.present   = present;
        it.last_item = last;
        it.now_ms    = stamp;
        return it;
    endfunction

    // Split a half-pixel centre into a random pair of box coordinates
    function automatic box_item_t make_box(input bit cam, input longint cx2, input longint cy2,
                                           input bit present, input bit last,
                                           input logic [TIME_W-1:0] stamp);
        longint lo_x, hi_x, lo_y, hi_y, l, t;
        lo_x = (cx2 > COORD_MAX) ? cx2 - COORD_MAX : 0;
        hi_x = (cx2 < COORD_MAX) ? cx2 : COORD_MAX;
        lo_y = (cy2 > COORD_MAX) ? cy2 - COORD_MAX : 0;
        hi_y = (cy2 < COORD_MAX) ? cy2 : COORD_MAX;
        l = lo_x + $urandom_range(int'(hi_x - lo_x));
        t = lo_y + $urandom_range(int'(hi_y - lo_y));
        return raw_item(cam, int'(l), int'(t), int'(cx2 - l), int'(cy2 - t),
                        present, last, stamp);
    endfunction

    // Choose a centre near the zone: vertex, edge midpoint, centroid, offset or anywhere
    function automatic void pick_centre(input bit cam, output longint cx2, output longint cy2);
        int unsigned mode, v, w;
        longint      sx, sy;
        mode = $urandom_range(9);
        v    = $urandom_range(NUM_VERTICES - 1);
        w    = (v + 1) % NUM_VERTICES;
        sx   = 0;
        sy   = 0;
        case (mode)
            0, 1:
            begin
                cx2 = vert_coord(cam, v, 1'b0);
                cy2 = vert_coord(cam, v, 1'b1);
            end
            2, 3:
            begin
                cx2 = (vert_coord(cam, v, 1'b0) + vert_coord(cam, w, 1'b0)) / 2;
                cy2 = (vert_coord(cam, v, 1'b1) + vert_coord(cam, w, 1'b1)) / 2;
            end
            4, 5:
            begin
                for (int i = 0; i < NUM_VERTICES; i++)
                begin
                    sx += vert_coord(cam, i, 1'b0);
                    sy += vert_coord(cam, i, 1'b1);
                end
                cx2 = sx / NUM_VERTICES;
                cy2 = sy / NUM_VERTICES;
            end
            6, 7:
            begin
                cx2 = vert_coord(cam, v, 1'b0) + longint'($urandom_range(8)) - 4;
                cy2 = vert_coord(cam, v, 1'b1) + longint'($urandom_range(8)) - 4;
            end
            default:
            begin
                cx2 = longint'($urandom_range(PT_MAX));
                cy2 = longint'($urandom_range(PT_MAX));
            end
        endcase
        cx2 = (cx2 < 0) ? 0 : ((cx2 > PT_MAX) ? PT_MAX : cx2);
        cy2 = (cy2 < 0) ? 0 : ((cy2 > PT_MAX) ? PT_MAX : cy2);
    endfunction

    // Advance a camera's clock: mostly small steps, sometimes wrap or jump
    function automatic logic [TIME_W-1:0] next_stamp(input bit cam);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            cam_clock[cam] += $urandom_range(2000);
        else if (roll < 85)
            cam_clock[cam] += $urandom;
        else
            cam_clock[cam] = $urandom;
        return cam_clock[cam];
    endfunction

    // Mostly well-formed boxes aimed at the zone, some foreign camera,
    // empty markers and pure noise
    function automatic box_item_t shaped_item(input bit cam, input bit last);
        int unsigned roll;
        bit          item_cam;
        longint      cx2, cy2;
        box_item_t   it;
        roll     = $urandom_range(99);
        item_cam = (roll < 10) ? !cam : cam;
        if (roll >= 90)
        begin
            it = raw_item(item_cam, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                          1'($urandom_range(1)), last, $urandom);
            return it;
        end
        pick_centre(item_cam, cx2, cy2);
        return make_box(item_cam, cx2, cy2, !(roll >= 10 && roll < 20), last,
                        last ? next_stamp(item_cam) : $urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // No zone loaded after reset: nothing is inside, nothing alerts
    task automatic test_reset_values();
        send_item(raw_item(1'b0, 0, 0, 0, 0, 1'b1, 1'b0, 32'd0));
        send_item(raw_item(1'b1, 2000, 2000, 2000, 2000, 1'b1, 1'b1, 32'd500));
        send_item(raw_item(1'b0, 100, 100, 300, 300, 1'b0, 1'b1, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    // Square zone on camera 0, full frame on camera 1, interleaved items
    task automatic test_zone_geometry();
        set_zone(1'b0, '{100, 300, 300, 100}, '{100, 100, 300, 300});
        set_zone(1'b1, '{0, COORD_MAX, COORD_MAX, 0}, '{0, 0, COORD_MAX, COORD_MAX});
        write_reg(zia_pkg::CFG_ZONE_MASK, 48'd3);
        write_reg(zia_pkg::CFG_COOLDOWN, 48'd0);
        end_config();
        send_item(raw_item(1'b0, 150, 150, 250, 250, 1'b1, 1'b0, 32'd0));
        // on the left edge, on a vertex, half a pixel outside
        send_item(raw_item(1'b0, 100, 200, 100, 200, 1'b1, 1'b0, 32'd0));
        send_item(raw_item(1'b0, 300, 300, 300, 300, 1'b1, 1'b0, 32'd0));
        send_item(raw_item(1'b0, 99, 200, 100, 200, 1'b1, 1'b0, 32'd0));
        send_item(raw_item(1'b0, 0, 0, 0, 0, 1'b1, 1'b0, 32'd0));
        send_item(raw_item(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                           1'b1, 1'b0, 32'd0));
        // empty marker over the zone centre
        send_item(raw_item(1'b0, 200, 200, 200, 200, 1'b0, 1'b0, 32'd0));
        // other camera adds to the shared counter
        send_item(raw_item(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                           1'b1, 1'b0, 32'd0));
        send_item(raw_item(1'b1, COORD_MAX, 0, 0, COORD_MAX, 1'b1, 1'b0, 32'd0));
        send_item(raw_item(1'b0, 200, 200, 200, 200, 1'b1, 1'b1, 32'd1000));
        send_item(raw_item(1'b1, 0, 0, 0, 0, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_item(raw_item(1'b0, 0, 0, 0, 0, 1'b1, 1'b1, 32'd1000));
        send_item(raw_item(1'b0, 200, 200, 200, 200, 1'b1, 1'b1, 32'd1001));
        wait_drained();
    endtask

    // Rising edge, cooldown, inactive zone and a single-point zone
    task automatic test_alert_edges();
        write_reg(zia_pkg::CFG_ZONE_MASK, 48'd1);
        write_reg(zia_pkg::CFG_COOLDOWN, 48'd1000);
        end_config();
        send_item(raw_item(1'b0, 200, 200, 200, 200, 1'b1, 1'b1, 32'd1500));
        send_item(raw_item(1'b0, 0, 0, 0, 0, 1'b1, 1'b1, 32'd1600));
        send_item(raw_item(1'b0, 200, 200, 200, 200, 1'b1, 1'b1, 32'd1700));
        send_item(raw_item(1'b0, 0, 0, 0, 0, 1'b1, 1'b1, 32'd2000));
        send_item(raw_item(1'b0, 200, 200, 200, 200, 1'b1, 1'b1, 32'd2001));
        send_item(raw_item(1'b1, 200, 200, 200, 200, 1'b1, 1'b1, 32'd2002));
        wait_drained();
        set_zone(1'b1, '{500, 500, 500, 500}, '{500, 500, 500, 500});
        write_reg(zia_pkg::CFG_ZONE_MASK, 48'd3);
        write_reg(zia_pkg::CFG_COOLDOWN, 48'h7FFF_FFFF);
        end_config();
        send_item(raw_item(1'b1, 500, 500, 500, 500, 1'b1, 1'b0, 32'd0));
        send_item(raw_item(1'b1, 500, 500, 501, 500, 1'b1, 1'b1, 32'h7FFF_FFFF));
        send_item(raw_item(1'b0, 0, 0, 0, 0, 1'b1, 1'b1, 32'd0));
        wait_drained();
        write_reg(zia_pkg::CFG_ZONE_MASK, 48'd0);
        end_config();
        send_item(raw_item(1'b0, 200, 200, 200, 200, 1'b1, 1'b1, 32'd5000));
        wait_drained();
    endtask

    // Drive more hits than the counter holds within one frame
    task automatic test_hit_saturation();
        set_zone(1'b0, '{0, COORD_MAX, COORD_MAX, 0}, '{0, 0, COORD_MAX, COORD_MAX});
        write_reg(zia_pkg::CFG_ZONE_MASK, 48'd1);
        write_reg(zia_pkg::CFG_COOLDOWN, 48'd0);
        end_config();
        for (int k = 0; k < HIT_MAX + 5; k++)
            send_item(make_box(1'b0, longint'($urandom_range(PT_MAX)),
                               longint'($urandom_range(PT_MAX)), 1'b1, 1'b0, $urandom));
        send_item(make_box(1'b0, longint'($urandom_range(PT_MAX)),
                           longint'($urandom_range(PT_MAX)), 1'b1, 1'b1, $urandom));
        wait_drained();
    endtask

    // Hold the output off while the sender keeps offering items
    task automatic test_backpressure();
        steady_src = 1'b1;
        hold_reqs <= hold_reqs + 1;
        for (int k = 0; k < 40; k++)
            send_item(shaped_item(1'($urandom_range(1)), ($urandom_range(4) == 0)));
        steady_src = 1'b0;
        wait_drained();
    endtask

    // Random phases: reload zones and alert settings, then stream frames
    task automatic test_random_frames();
        int               sent;
        int               len;
        bit               cam;
        logic [COOLDOWN_W-1:0] cd;
        logic [NUM_CAMERAS-1:0] mask;
        for (int ph = 0; ph < 8; ph++)
        begin
            random_zone(1'b0);
            random_zone(1'b1);
            if (ph == 0)
                cd = '0;
            else if (ph == 1)
                cd = '1;
            else if ($urandom_range(9) < 6)
                cd = COOLDOWN_W'($urandom_range(1500));
            else
                cd = COOLDOWN_W'($urandom);
            if (ph == 2)
                mask = '0;
            else if ($urandom_range(9) < 7)
                mask = '1;
            else
                mask = NUM_CAMERAS'($urandom_range(3));
            write_reg(zia_pkg::CFG_ZONE_MASK, pad_noise(CFG_DATA_W'(mask), NUM_CAMERAS));
            write_reg(zia_pkg::CFG_COOLDOWN, pad_noise(CFG_DATA_W'(cd), COOLDOWN_W));
            end_config();
            // keep one phase free of idling on both sides
            steady_src = (ph == 3);
            steady_sink <= (ph == 3);
            sent = 0;
            while (sent < 100)
            begin
                cam = 1'($urandom_range(1));
                len = $urandom_range(6, 1);
                for (int k = 0; k < len; k++)
                    send_item(shaped_item(cam, k == len - 1));
                sent += len;
            end
            wait_drained();
        end
        steady_src = 1'b0;
        steady_sink <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (prev_intrusion[c])
        begin
            prev_intrusion[c] = 1'b0;
            last_alert_ms[c]  = '0;
            cam_clock[c]      = '0;
            zone_words[c][0]  = '0;
            zone_words[c][1]  = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_zone_geometry();
        test_alert_edges();
        test_hit_saturation();
        test_backpressure();
        test_random_frames();
        wait_drained();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
